@@ rtl/stx_pkg.sv @@
// Shared types and constants for the STX/ETX frame receiver.
`timescale 1ns / 1ps

package stx_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START_BYTE = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_END_BYTE   = 8'd1;

  localparam logic [ByteW-1:0] START_BYTE_RST = 8'h02;
  localparam logic [ByteW-1:0] END_BYTE_RST   = 8'h03;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  frame_length;
  } result_t;

endpackage

@@ rtl/stx_parser.sv @@
// Frame parser: header decode, payload count, running checksum and frame verdict.
`timescale 1ns / 1ps

module stx_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [stx_pkg::ByteW-1:0] rx_byte_i,
  input  logic [stx_pkg::ByteW-1:0] start_byte_i,
  input  logic [stx_pkg::ByteW-1:0] end_byte_i,
  output logic                    res_valid_o,
  output stx_pkg::result_t        res_o
);
  import stx_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LEN_LO  = 3'd1;
  localparam logic [2:0] ST_LEN_HI  = 3'd2;
  localparam logic [2:0] ST_CSUM    = 3'd3;
  localparam logic [2:0] ST_PAYLOAD = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  remain_q, remain_d;   // payload bytes still to come
  logic [ByteW-1:0] exp_sum_q, exp_sum_d;
  logic [ByteW-1:0] sum_q, sum_d;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    remain_d    = remain_q;
    exp_sum_d   = exp_sum_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PAYLOAD, payload_byte: '0, frame_length: '0};
    if (accept_i) begin
      case (state_q)
        ST_IDLE: begin
          if (rx_byte_i == start_byte_i) state_d = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          len_d   = {{(LenW-ByteW){1'b0}}, rx_byte_i};
          state_d = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          len_d    = {rx_byte_i, len_q[ByteW-1:0]};
          remain_d = {rx_byte_i, len_q[ByteW-1:0]};
          state_d  = ST_CSUM;
        end
        ST_CSUM: begin
          exp_sum_d = rx_byte_i;
          sum_d     = '0;
          state_d   = ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          res_valid_o = 1'b1;
          if (remain_q == '0) begin
            // closing byte
            res_o.kind = ((rx_byte_i == end_byte_i) && (sum_q == exp_sum_q)) ?
                         KIND_GOOD : KIND_ERROR;
            res_o.frame_length = len_q;
            state_d = ST_IDLE;
          end else begin
            res_o.payload_byte = rx_byte_i;
            sum_d    = sum_q + rx_byte_i;
            remain_d = remain_q - 1'b1;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      remain_q  <= '0;
      exp_sum_q <= '0;
      sum_q     <= '0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      remain_q  <= remain_d;
      exp_sum_q <= exp_sum_d;
      sum_q     <= sum_d;
    end
  end

endmodule

@@ rtl/stx_out_buf.sv @@
// Output register with skid stage for result transfers.
`timescale 1ns / 1ps

module stx_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stx_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output stx_pkg::result_t out_data_o
);
  import stx_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/stx_etx_frame_receiver.sv @@
// Top level of the STX/ETX length and checksum frame receiver.
//
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_stall_o   rx_byte_i
//  out      output     out_valid_o / out_stall_i result_kind_o, payload_byte_o, frame_length_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle while in_stall_o is low; each result is registered in stx_out_buf.
// The parser state advances once per accepted byte.
// in_stall_o rises only once the output register and the skid stage both hold results.
// Reset clears the parser to idle and the registers to start 0x02, end 0x03.
`timescale 1ns / 1ps

module stx_etx_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [stx_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  result_kind_o,
  output logic [stx_pkg::ByteW-1:0]   payload_byte_o,
  output logic [stx_pkg::LenW-1:0]    frame_length_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [stx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [stx_pkg::ByteW-1:0]   cfg_data_i
);
  import stx_pkg::*;

  logic [ByteW-1:0] start_byte_q, end_byte_q;
  logic             accept;
  logic             res_valid;
  result_t          res, out_data;
  logic             buf_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      end_byte_q   <= END_BYTE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_START_BYTE) start_byte_q <= cfg_data_i;
      if (cfg_index_i == REG_END_BYTE)   end_byte_q   <= cfg_data_i;
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  stx_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .start_byte_i(start_byte_q),
    .end_byte_i  (end_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  stx_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign result_kind_o  = out_data.kind;
  assign payload_byte_o = out_data.payload_byte;
  assign frame_length_o = out_data.frame_length;

  // skid stage only fills behind a held output
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result on the output");

  a_payload_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_PAYLOAD) |-> frame_length_o == '0)
    else $error("payload transfer carries a frame length");

  a_verdict_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != KIND_PAYLOAD) |-> payload_byte_o == '0)
    else $error("frame verdict carries a payload byte");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_kind_o == KIND_PAYLOAD || result_kind_o == KIND_GOOD ||
                     result_kind_o == KIND_ERROR))
    else $error("unknown result kind");

endmodule
